// File: hdl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned RoundsDefault = 10;
  localparam int unsigned OpW = 3;
  localparam int unsigned IdxW = 6;
  localparam int unsigned InDataW = OpW + IdxW + 32 + 64 + 64;  // 169
  localparam int unsigned InTdataW = 176;
  localparam int unsigned OutTdataW = 128;

  typedef enum logic [2:0] {
    OpKeyWrite = 3'd0,
    OpEncrypt  = 3'd1,
    OpDecrypt  = 3'd2,
    OpLoadCtr  = 3'd3,
    OpCtr      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StInit,
    StRound,
    StOut
  } state_e;

  typedef logic [7:0] sbox_tbl_t [256];

  localparam sbox_tbl_t Sbox = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam sbox_tbl_t InvSbox = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte k sits at bits 127-8k
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int unsigned src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          src = r + 4 * c;
          o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = InvSbox[s[127 - 8 * src -: 8]];
        end else begin
          src = r + 4 * ((c + r) % 4);
          o[127 - 8 * (r + 4 * c) -: 8] = Sbox[s[127 - 8 * src -: 8]];
        end
      end
    end
    sub_shift = o;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, x2, x4, x8;
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] y;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a0 = s[127 - 8 * (4 * c + j) -: 8];
        x2 = xt(a0);
        x4 = xt(x2);
        x8 = xt(x4);
        m1[j] = a0;
        m2[j] = x2;
        m4[j] = x4;
        m8[j] = x8;
      end
      for (int r = 0; r < 4; r++) begin
        y = '0;
        for (int j = 0; j < 4; j++) begin
          a1 = m1[j];
          a2 = m2[j];
          a3 = m4[j];
          unique case ((j - r + 4) % 4)
            0: y = y ^ (inv ? (m8[j] ^ a3 ^ a2) : a2);
            1: y = y ^ (inv ? (m8[j] ^ a2 ^ a1) : (a2 ^ a1));
            2: y = y ^ (inv ? (m8[j] ^ a3 ^ a1) : a1);
            default: y = y ^ (inv ? (m8[j] ^ a1) : a1);
          endcase
        end
        o[127 - 8 * (4 * c + r) -: 8] = y;
      end
    end
    mix = o;
  endfunction

endpackage

// File: hdl/aes_key_mem.sv
module aes_key_mem #(
  parameter int unsigned Words = 44,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [127:0]     wdata_i,
  input  logic [15:0]      wbe_i,
  input  logic [AddrW-3:0] raddr_i,
  output logic [127:0]     rdata_o
);
  // one row holds the four words of a round key
  localparam int unsigned Rows = Words / 4;
  logic [127:0] mem_q [Rows];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 16; b++) begin
        if (wbe_i[b]) mem_q[waddr_i[AddrW-1:2]][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/aes_block_cipher_ctr_core.sv
// steps: encrypt, decrypt and ctr run the initial key add in StInit, then ROUNDS
//   rounds in StRound, before the result is valid
// blocks: a new block is taken only in idle, once the last is through, set by the
//   single shared round unit and the one read port of the round-key memory
// reset: rst_ni clears control and the counter; round keys are undefined until written
module aes_block_cipher_ctr_core #(
  parameter int unsigned Rounds = aes_pkg::RoundsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], key_index[8:3], key_word[40:9], data_hi[104:41], data_lo[168:105]
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_hi[63:0], result_lo[127:64]
  output logic [127:0] m_axis_tdata
);
  localparam int unsigned Words = 4 * (Rounds + 1);
  localparam int unsigned AddrW = $clog2(Words);
  localparam int unsigned RowW = AddrW - 2;

  aes_pkg::state_e state_q, state_d;
  logic [RowW-1:0] rnd_q, rnd_d;
  logic            inv_q;
  logic            ctr_op_q;
  logic [127:0]    st_q, st_d;
  logic [127:0]    din_q;
  logic [127:0]    ctr_q;
  logic            out_vld_q;
  logic [127:0]    out_q;

  logic [2:0]       op;
  logic [5:0]       kidx;
  logic [31:0]      kword;
  logic [63:0]      dhi, dlo;
  logic             in_xfer;
  logic             key_we;
  logic [127:0]     key_wdata;
  logic [15:0]      key_wbe;
  logic [RowW-1:0]  key_raddr;
  logic [127:0]     rk;
  logic [127:0]     sub, mixed, last;
  logic             final_rnd;

  assign op    = s_axis_tdata[2:0];
  assign kidx  = s_axis_tdata[8:3];
  assign kword = s_axis_tdata[40:9];
  assign dhi   = s_axis_tdata[104:41];
  assign dlo   = s_axis_tdata[168:105];

  // the output register frees up on its own transfer
  assign s_axis_tready = (state_q == aes_pkg::StIdle) && !(out_vld_q && !m_axis_tready);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // key word lands in its lane of the row, word 0 at the top
  assign key_we    = in_xfer && (op == aes_pkg::OpKeyWrite) && (32'(kidx) < Words);
  assign key_wdata = {4{kword}};
  always_comb begin
    key_wbe = '0;
    key_wbe[15 - 4 * kidx[1:0] -: 4] = 4'hf;
  end

  always_comb begin
    priority if (state_q == aes_pkg::StIdle) begin
      key_raddr = (op == aes_pkg::OpDecrypt) ? RowW'(Rounds) : '0;
    end else begin
      key_raddr = rnd_d;
    end
  end

  aes_key_mem #(.Words(Words), .AddrW(AddrW)) u_key_mem (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(kidx[AddrW-1:0]),
    .wdata_i(key_wdata),
    .wbe_i  (key_wbe),
    .raddr_i(key_raddr),
    .rdata_o(rk)
  );

  // shared round unit: forward is sub_shift, mix, key; inverse is sub_shift, key, mix; final round skips mix
  assign sub       = aes_pkg::sub_shift(st_q, inv_q);
  assign final_rnd = inv_q ? (rnd_q == '0) : (rnd_q == RowW'(Rounds));
  assign mixed     = inv_q ? aes_pkg::mix(sub ^ rk, 1'b1) : (aes_pkg::mix(sub, 1'b0) ^ rk);
  assign last      = sub ^ rk;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes_pkg::StIdle: begin
        if (in_xfer && (op == aes_pkg::OpEncrypt || op == aes_pkg::OpDecrypt
            || op == aes_pkg::OpCtr)) state_d = aes_pkg::StInit;
      end
      aes_pkg::StInit: state_d = aes_pkg::StRound;
      aes_pkg::StRound: if (final_rnd) state_d = aes_pkg::StIdle;
      default: state_d = aes_pkg::StIdle;
    endcase
  end

  always_comb begin
    rnd_d = rnd_q;
    st_d  = st_q;
    unique case (state_q)
      aes_pkg::StIdle: begin
        rnd_d = (op == aes_pkg::OpDecrypt) ? RowW'(Rounds) : '0;
        st_d  = (op == aes_pkg::OpCtr) ? ctr_q : {dhi, dlo};
      end
      aes_pkg::StInit: begin
        st_d  = st_q ^ rk;
        rnd_d = inv_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
      end
      aes_pkg::StRound: begin
        st_d  = final_rnd ? last : mixed;
        rnd_d = inv_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aes_pkg::StIdle;
      rnd_q     <= '0;
      out_vld_q <= 1'b0;
      ctr_q     <= '0;
      inv_q     <= 1'b0;
      ctr_op_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == aes_pkg::StIdle || state_q == aes_pkg::StInit
          || state_q == aes_pkg::StRound) rnd_q <= rnd_d;
      if (in_xfer) begin
        inv_q    <= (op == aes_pkg::OpDecrypt);
        ctr_op_q <= (op == aes_pkg::OpCtr);
        if (op == aes_pkg::OpLoadCtr) ctr_q <= {dhi, dlo};
      end
      if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
      if (state_q == aes_pkg::StRound && final_rnd) begin
        out_vld_q <= 1'b1;
        // carry through bytes 15 down to 1, byte 0 stays
        if (ctr_op_q) ctr_q <= {ctr_q[127:120], ctr_q[119:0] + 120'd1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (in_xfer) din_q <= (op == aes_pkg::OpCtr) ? {dhi, dlo} : '0;
    if (state_q == aes_pkg::StRound && final_rnd) out_q <= last ^ din_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};
endmodule

// File: hdl/aes_core_checker.sv
module aes_core_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_accept_frees_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result still pending after input transfer");
  a_no_out_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid || !rst_ni)
    else $error("result after reset");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("accepted while result stalled");
endmodule

bind aes_block_cipher_ctr_core aes_core_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
